>>> rtl/lpg_pkg.sv
// Shared constants, register codes and pipeline stage types for the
// letterbox point mapper. No dependencies; every other file uses it.
package lpg_pkg;

  // coordinate width of sizes and guest coordinates
  localparam int COORD_BITS = 13;
  // window point fields carry one more bit for the sign
  localparam int IN_BITS = COORD_BITS + 1;
  // register index width on the config channel
  localparam int CFG_IDX_BITS = 4;

  // divider pipeline: quotient bits resolved per stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_BPS = (COORD_BITS + DIV_STAGES - 1) / DIV_STAGES;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_WIDTH  = CFG_IDX_BITS'(0),
    REG_WINDOW_HEIGHT = CFG_IDX_BITS'(1),
    REG_SCREEN_WIDTH  = CFG_IDX_BITS'(2),
    REG_SCREEN_HEIGHT = CFG_IDX_BITS'(3)
  } cfg_reg_t;

  // register reset values
  localparam logic [COORD_BITS-1:0] RST_WINDOW_WIDTH  = COORD_BITS'(1920);
  localparam logic [COORD_BITS-1:0] RST_WINDOW_HEIGHT = COORD_BITS'(1080);
  localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = COORD_BITS'(1920);
  localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = COORD_BITS'(1080);

  // stage 1: point plus geometry cross products
  typedef struct packed {
    logic signed [COORD_BITS:0] px;
    logic signed [COORD_BITS:0] py;
    logic                       wlim;  // width limits the scale
    logic                       zero;  // some size register is zero
    logic [2*COORD_BITS-1:0]    wbgl;  // barred window size * limiting guest size
    logic [2*COORD_BITS-1:0]    gbwl;  // barred guest size * limiting window size
  } s1_t;

  // stage 2: point products along both axes
  typedef struct packed {
    logic signed [COORD_BITS:0]     pf;      // point on the limiting axis
    logic [COORD_BITS-1:0]          wf;      // limiting window size
    logic signed [2*COORD_BITS+1:0] prod_f;  // pf * limiting guest size
    logic signed [2*COORD_BITS+1:0] prod_b;  // barred point * limiting guest size
    logic [2*COORD_BITS-1:0]        wbgl;
    logic [2*COORD_BITS-1:0]        gbwl;
    logic                           wlim;
    logic                           zero;
  } s2_t;

  // divider stages: remainder in the upper half, dividend/quotient below
  typedef struct packed {
    logic                    ok;
    logic                    wlim;
    logic [COORD_BITS-1:0]   divisor;
    logic [2*COORD_BITS-1:0] w_full;
    logic [2*COORD_BITS-1:0] w_bar;
  } div_t;

endpackage

>>> rtl/lpg_in_if.sv
// Input channel of the letterbox point mapper: one window point per item.
// Depends on lpg_pkg.
interface lpg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lpg_pkg::IN_BITS-1:0]    point_x;
  logic signed [lpg_pkg::IN_BITS-1:0]    point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

>>> rtl/lpg_out_if.sv
// Result channel of the letterbox point mapper: guest coordinates per item.
// Depends on lpg_pkg.
interface lpg_out_if;
  logic                              valid;
  logic                              ready;
  logic [lpg_pkg::COORD_BITS-1:0]    mapped_x;
  logic [lpg_pkg::COORD_BITS-1:0]    mapped_y;
  logic                              inside_res;

  modport source (output valid, output mapped_x, output mapped_y, output inside_res,
                  input ready);
  modport sink   (input valid, input mapped_x, input mapped_y, input inside_res,
                  output ready);
endinterface

>>> rtl/lpg_cfg_if.sv
// Configuration write channel of the letterbox point mapper.
// Depends on lpg_pkg.
interface lpg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lpg_pkg::CFG_IDX_BITS-1:0]   reg_index;
  logic [lpg_pkg::COORD_BITS-1:0]     reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

>>> rtl/letterbox_point_to_guest_core.sv
// Letterbox point mapper top level: config registers, product stages and a
// pipelined restoring divider. Depends on lpg_pkg and the three channel interfaces.
//
//  channel    dir  payload                              handshake
//  in_chan    in   point_x, point_y (signed)            valid/ready
//  out_chan   out  mapped_x, mapped_y, inside_res        valid/ready
//  cfg_chan   in   reg_index, reg_data                   valid/ready, always ready
//
// One item per cycle sustained while out_chan is ready. Stages in order:
// geometry products, point products, numerator and range checks, DIV_STAGES
// divider stages of DIV_BPS quotient bits each, output register.
// Every stage has its own valid bit and loads when it is empty or its successor
// moves, so bubbles close up and a stalled output still lets items enter.
// Synchronous active-low reset clears valid bits and restores the config registers.
module letterbox_point_to_guest_core (
  input  logic              clk,
  input  logic              rst_n,
  lpg_in_if.sink            in_chan,
  lpg_out_if.source         out_chan,
  lpg_cfg_if.sink           cfg_chan
);

  localparam int C   = lpg_pkg::COORD_BITS;
  localparam int NDS = lpg_pkg::DIV_STAGES;
  localparam int BPS = lpg_pkg::DIV_BPS;

  // run up to BPS restoring steps, starting at quotient step first
  function automatic logic [2*C-1:0] div_steps(input logic [2*C-1:0] w_in,
                                               input logic [C-1:0] d,
                                               input int first);
    logic [2*C-1:0] w;
    logic [C:0]     t;
    logic [C:0]     diff;
    w = w_in;
    for (int k = 0; k < BPS; k++) begin
      if (first + k < C) begin
        t    = w[2*C-1:C-1];
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
          w = {diff[C-1:0], w[C-2:0], 1'b1};
        end else begin
          w = {t[C-1:0], w[C-2:0], 1'b0};
        end
      end
    end
    return w;
  endfunction

  // configuration registers
  logic [C-1:0] ww_r, wh_r, sw_r, sh_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ww_r <= lpg_pkg::RST_WINDOW_WIDTH;
      wh_r <= lpg_pkg::RST_WINDOW_HEIGHT;
      sw_r <= lpg_pkg::RST_SCREEN_WIDTH;
      sh_r <= lpg_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_chan.valid) begin
      unique case (lpg_pkg::cfg_reg_t'(cfg_chan.reg_index))
        lpg_pkg::REG_WINDOW_WIDTH:  ww_r <= cfg_chan.reg_data;
        lpg_pkg::REG_WINDOW_HEIGHT: wh_r <= cfg_chan.reg_data;
        lpg_pkg::REG_SCREEN_WIDTH:  sw_r <= cfg_chan.reg_data;
        lpg_pkg::REG_SCREEN_HEIGHT: sh_r <= cfg_chan.reg_data;
        default: ;
      endcase
    end
  end

  // pipeline registers and stage readiness
  lpg_pkg::s1_t  s1_r, s1_nxt;
  lpg_pkg::s2_t  s2_r, s2_nxt;
  lpg_pkg::div_t dst_r   [0:NDS];
  lpg_pkg::div_t dst_nxt [0:NDS];
  logic          v1_r, v2_r, vo_r;
  logic [NDS:0]  dvld_r;
  logic [NDS:0]  rdy_d;
  logic          rdy1, rdy2, rdy_o;
  logic [C-1:0]  out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic          out_in_r;

  // ready chain from the output back to the input
  always_comb begin
    rdy_o      = !vo_r || out_chan.ready;
    rdy_d[NDS] = !dvld_r[NDS] || rdy_o;
    for (int s = NDS - 1; s >= 0; s--) begin
      rdy_d[s] = !dvld_r[s] || rdy_d[s+1];
    end
    rdy2 = !v2_r || rdy_d[0];
    rdy1 = !v1_r || rdy2;
  end

  assign in_chan.ready = rdy1;

  // stage 1: geometry cross products and the limiting axis
  logic [2*C-1:0] prod_a, prod_b;
  always_comb begin
    prod_a      = ww_r * sh_r;
    prod_b      = wh_r * sw_r;
    s1_nxt.px   = in_chan.point_x;
    s1_nxt.py   = in_chan.point_y;
    s1_nxt.wlim = (prod_a <= prod_b);
    s1_nxt.zero = (ww_r == '0) || (wh_r == '0) || (sw_r == '0) || (sh_r == '0);
    s1_nxt.wbgl = s1_nxt.wlim ? prod_b : prod_a;
    s1_nxt.gbwl = s1_nxt.wlim ? prod_a : prod_b;
  end

  // stage 2: point products, both scaled by the limiting guest size
  logic signed [C:0] pb, gf_s;
  logic [C-1:0]      gf;
  always_comb begin
    s2_nxt.pf     = s1_r.wlim ? s1_r.px : s1_r.py;
    pb            = s1_r.wlim ? s1_r.py : s1_r.px;
    gf            = s1_r.wlim ? sw_r : sh_r;
    s2_nxt.wf     = s1_r.wlim ? ww_r : wh_r;
    gf_s          = signed'({1'b0, gf});
    s2_nxt.prod_f = s2_nxt.pf * gf_s;
    s2_nxt.prod_b = pb * gf_s;
    s2_nxt.wbgl   = s1_r.wbgl;
    s2_nxt.gbwl   = s1_r.gbwl;
    s2_nxt.wlim   = s1_r.wlim;
    s2_nxt.zero   = s1_r.zero;
  end

  // stage 3: barred numerator, range checks, dividends; then divider steps
  logic signed [2*C+2:0] num;
  logic                  full_ok, num_ok;
  always_comb begin
    full_ok = !s2_r.zero && !s2_r.pf[C] && (s2_r.pf[C-1:0] < s2_r.wf);
    num     = signed'({s2_r.prod_b, 1'b0}) - signed'({3'b000, s2_r.wbgl})
              + signed'({3'b000, s2_r.gbwl});
    num_ok  = !num[2*C+2] && (num[2*C+1:0] < {1'b0, s2_r.gbwl, 1'b0});
    dst_nxt[0].ok      = full_ok && num_ok;
    dst_nxt[0].wlim    = s2_r.wlim;
    dst_nxt[0].divisor = s2_r.wf;
    dst_nxt[0].w_full  = s2_r.prod_f[2*C-1:0];
    // floor(n / 2w) is floor(floor(n / 2) / w)
    dst_nxt[0].w_bar   = num[2*C:1];
    for (int s = 1; s <= NDS; s++) begin
      dst_nxt[s]        = dst_r[s-1];
      dst_nxt[s].w_full = div_steps(dst_r[s-1].w_full, dst_r[s-1].divisor, (s - 1) * BPS);
      dst_nxt[s].w_bar  = div_steps(dst_r[s-1].w_bar, dst_r[s-1].divisor, (s - 1) * BPS);
    end
  end

  // output fields: full axis quotient is x when width limits, else y
  always_comb begin
    out_x_nxt = '0;
    out_y_nxt = '0;
    if (dst_r[NDS].ok) begin
      if (dst_r[NDS].wlim) begin
        out_x_nxt = dst_r[NDS].w_full[C-1:0];
        out_y_nxt = dst_r[NDS].w_bar[C-1:0];
      end else begin
        out_x_nxt = dst_r[NDS].w_bar[C-1:0];
        out_y_nxt = dst_r[NDS].w_full[C-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      dvld_r <= '0;
      vo_r   <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_chan.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy_d[0]) dvld_r[0] <= v2_r;
      for (int s = 1; s <= NDS; s++) begin
        if (rdy_d[s]) dvld_r[s] <= dvld_r[s-1];
      end
      if (rdy_o) vo_r <= dvld_r[NDS];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_chan.valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
    if (rdy_d[0] && v2_r) dst_r[0] <= dst_nxt[0];
    for (int s = 1; s <= NDS; s++) begin
      if (rdy_d[s] && dvld_r[s-1]) dst_r[s] <= dst_nxt[s];
    end
    if (rdy_o && dvld_r[NDS]) begin
      out_x_r  <= out_x_nxt;
      out_y_r  <= out_y_nxt;
      out_in_r <= dst_r[NDS].ok;
    end
  end

  assign out_chan.valid      = vo_r;
  assign out_chan.mapped_x   = out_x_r;
  assign out_chan.mapped_y   = out_y_r;
  assign out_chan.inside_res = out_in_r;

  // a full pipeline behind a stalled output takes no item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && (&dvld_r) && vo_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("item taken while every stage is full and the output is stalled");

  // accepted items keep their partial remainders below the divisor
  a_rem_full: assert property (@(posedge clk) disable iff (!rst_n)
    (dvld_r[NDS] && dst_r[NDS].ok) |-> (dst_r[NDS].w_full[2*C-1:C] < dst_r[NDS].divisor))
    else $error("full-axis remainder not below divisor");

  a_rem_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (dvld_r[NDS] && dst_r[NDS].ok) |-> (dst_r[NDS].w_bar[2*C-1:C] < dst_r[NDS].divisor))
    else $error("barred-axis remainder not below divisor");

endmodule
